/* src/deq_pkg.sv */
// Shared types and constants for the double-ended queue block.
// Holds command and status codes and the control bundle that drives the cell row.
// No dependencies.
`default_nettype none

package deq_pkg;

  localparam int unsigned DEQ_DEPTH = 16;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell; only set for a legal request.
  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic rm_front;
  } deq_op_t;

endpackage : deq_pkg

`default_nettype wire

/* src/deq_in_if.sv */
// Request channel of the double-ended queue: valid/ready handshake plus payload.
// Depends on deq_pkg for field widths.
`default_nettype none

interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::CMD_W-1:0]           cmd;
  logic signed [deq_pkg::WORD_W-1:0]   value_in;

  modport source (output valid, output cmd, output value_in, input ready);
  modport sink   (input valid, input cmd, input value_in, output ready);
endinterface : deq_in_if

`default_nettype wire

/* src/deq_out_if.sv */
// Result channel of the double-ended queue: valid/ready handshake plus payload.
// Depends on deq_pkg for field widths.
`default_nettype none

interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::WORD_W-1:0]   value_out;
  logic [deq_pkg::STATUS_W-1:0]        status;
  logic [deq_pkg::COUNT_W-1:0]         count;
  logic                                is_empty_flag;

  modport source (output valid, output value_out, output status, output count,
                  output is_empty_flag, input ready);
  modport sink   (input valid, input value_out, input status, input count,
                  input is_empty_flag, output ready);
endinterface : deq_out_if

`default_nettype wire

/* src/deq_cell.sv */
// One storage cell of the queue row; cell IDX holds the entry IDX places from the front.
// Depends on deq_pkg for the control bundle and word width.
`default_nettype none

module deq_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  wire logic                                clk,
  input  wire deq_pkg::deq_op_t                    op,
  input  wire logic [CNT_W-1:0]                    cnt,
  input  wire logic signed [deq_pkg::WORD_W-1:0]   value_in,
  input  wire logic signed [deq_pkg::WORD_W-1:0]   left_data,
  input  wire logic signed [deq_pkg::WORD_W-1:0]   right_data,
  output logic signed [deq_pkg::WORD_W-1:0]        data,
  output logic signed [deq_pkg::WORD_W-1:0]        back_term
);
  import deq_pkg::*;

  logic signed [WORD_W-1:0] data_r;
  logic                     is_tail;
  logic                     is_next_free;

  assign is_next_free = (cnt == CNT_W'(IDX));
  assign is_tail      = (cnt == CNT_W'(IDX + 1));

  // Push front shifts every entry one cell toward the back; pop front shifts
  // toward the front. Pop back only moves the count, so the cell is left alone.
  always_ff @(posedge clk) begin
    if (op.ins_front) begin
      data_r <= left_data;
    end else if (op.rm_front) begin
      data_r <= right_data;
    end else if (op.ins_back && is_next_free) begin
      data_r <= value_in;
    end
  end

  assign data      = data_r;
  assign back_term = is_tail ? data_r : '0;

endmodule : deq_cell

`default_nettype wire

/* src/double_ended_queue_unit.sv */
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on deq_pkg, deq_in_if, deq_out_if and deq_cell.
//
// Usage:
//   in_ch carries one request (cmd, value_in); out_ch returns exactly one result
//   per request (value_out, status, count, is_empty_flag), in request order.
//   Entries live in a row of DEPTH cells with the front entry in cell 0. A push
//   or pop at the front shifts the whole row by one cell; a push at the back
//   writes the cell just past the last entry, and a read at the back selects
//   the cell that holds the last entry. The result is loaded into the output
//   register when the request is taken. Throughput: one request per cycle
//   while the receiver takes each result; a command moves the row by at most
//   one cell and the count by one step at most, or to zero for a clear.
//   A push on a full queue returns status full, a pop or peek on an empty queue
//   returns status empty; in both cases the queue is unchanged and value_out is
//   zero. Code seven is ignored and returns ok.
//   Reset empties the queue at once; the stored words are not cleared.
//   When the receiver stalls, the result is held and one more request is taken
//   only when the output register is freed in the same cycle.
`default_nettype none

module double_ended_queue_unit #(
  parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH
) (
  input wire logic clk,
  input wire logic rst_n,
  deq_in_if.sink   in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          cnt_nxt;
  logic                      out_vld_r;
  logic                      out_vld_nxt;
  logic signed [WORD_W-1:0]  out_value_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_empty_r;

  logic                      accept;
  logic                      full;
  logic                      empty;
  deq_op_t                   op;
  logic signed [WORD_W-1:0]  rd_value;
  status_t                   rd_status;
  logic signed [WORD_W-1:0]  back_value;

  logic signed [WORD_W-1:0]  cell_data [DEPTH];
  logic signed [WORD_W-1:0]  cell_back [DEPTH];

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r == CNT_W'(DEPTH));
  assign empty       = (cnt_r == '0);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] left_w;
    logic signed [WORD_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = in_ch.value_in;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    deq_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .cnt        (cnt_r),
      .value_in   (in_ch.value_in),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g]),
      .back_term  (cell_back[g])
    );
  end

  // Exactly one cell marks itself as the back entry when the queue is not empty.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | cell_back[i];
    end
  end

  always_comb begin
    op        = '0;
    cnt_nxt   = cnt_r;
    rd_value  = '0;
    rd_status = ST_OK;
    unique case (in_ch.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          rd_status = ST_FULL;
        end else begin
          op.ins_front = (in_ch.cmd == CMD_PUSH_FRONT) && accept;
          op.ins_back  = (in_ch.cmd == CMD_PUSH_BACK) && accept;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (empty) begin
          rd_status = ST_EMPTY;
        end else begin
          rd_value = cell_data[0];
          if (in_ch.cmd == CMD_POP_FRONT) begin
            op.rm_front = accept;
            cnt_nxt     = cnt_r - CNT_W'(1);
          end
        end
      end
      CMD_POP_BACK, CMD_PEEK_BACK: begin
        if (empty) begin
          rd_status = ST_EMPTY;
        end else begin
          rd_value = back_value;
          if (in_ch.cmd == CMD_POP_BACK) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      CMD_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= rd_value;
      out_status_r <= rd_status;
      out_count_r  <= COUNT_W'(cnt_nxt);
      out_empty_r  <= (cnt_nxt == '0);
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.value_out     = out_value_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.count         = out_count_r;
  assign out_ch.is_empty_flag = out_empty_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds the queue depth");

  a_push_front_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.cmd == CMD_PUSH_FRONT && !full)
      |=> cell_data[0] == $past(in_ch.value_in))
    else $error("front push did not land in the first cell");

  a_pop_back_count : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.cmd == CMD_POP_BACK && !empty)
      |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("back pop did not reduce the count by one");

  a_count_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_count_r == COUNT_W'(cnt_r) && out_empty_r == (cnt_r == '0)))
    else $error("pending result disagrees with the held count");

endmodule : double_ended_queue_unit

`default_nettype wire
